// ===== hw/rtl/cra_pkg.sv =====
// Shared types and constants of the crop region accumulator.
package cra_pkg;

   localparam int COORD_BITS = 12;
   localparam int WIDE_BITS = COORD_BITS + 1;
   localparam int SCORE_BITS = 16;
   localparam int MAG_BITS = SCORE_BITS - 1;
   localparam int ACC_BITS = 24;
   localparam int TALLY_BITS = 8;
   localparam int FRAC_BITS = 9;
   localparam int MODE_BITS = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam int REQ_FIELD_BITS = 4 * COORD_BITS + SCORE_BITS;
   localparam int REQ_DATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 4 * WIDE_BITS + ACC_BITS + 2 * TALLY_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS = 3;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [WIDE_BITS-1:0] wide_type;
   typedef logic [ACC_BITS-1:0] acc_type;
   typedef logic [TALLY_BITS-1:0] tally_type;

   localparam logic [MODE_BITS-1:0] MODE_MAX = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_SUM_REQ = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_SUM_ALL = 2'd2;
   localparam logic [MODE_BITS-1:0] MODE_ONE = 2'd3;

   localparam logic [1:0] COVER_NOT = 2'd0;
   localparam logic [1:0] COVER_PART = 2'd1;
   localparam logic [1:0] COVER_FULL = 2'd2;

   localparam logic [1:0] REG_TARGET_W = 2'd0;
   localparam logic [1:0] REG_TARGET_H = 2'd1;
   localparam logic [1:0] REG_COVERAGE = 2'd2;
   localparam logic [1:0] REG_MODE = 2'd3;

   // register values after reset
   localparam coord_type TARGET_W_RESET = 12'd1080;
   localparam coord_type TARGET_H_RESET = 12'd1920;
   localparam logic [FRAC_BITS-1:0] COVERAGE_RESET = 9'd179;

   localparam logic [FRAC_BITS-1:0] FRAC_ONE = 9'd256;
   localparam acc_type SCORE_ONE = 24'd256;
   localparam acc_type SCORE_SAT = '1;
   localparam tally_type TALLY_SAT = '1;

   // one classified request waiting for the back end
   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type w;
      coord_type h;
      wide_type xr;
      wide_type yb;
      wide_type cx;
      wide_type cy;
      coord_type trim_h;
      coord_type trim_v;
      logic score_ok;
      logic [MAG_BITS-1:0] score_mag;
      logic required;
      logic last;
   } item_type;

   // target write strobes and the value being written
   typedef struct packed {
      logic width_we;
      logic height_we;
      coord_type wdata;
   } cfg_type;

   typedef struct packed {
      wide_type x;
      wide_type y;
      wide_type w;
      wide_type h;
      logic region_empty;
      logic required_empty;
      logic required_fits;
      acc_type score;
      tally_type covered;
      tally_type optional;
   } result_type;

endpackage

// ===== hw/rtl/cra_front.sv =====
// Front end: classifies a request and works out its edges, centre and trims.
module cra_front (
   input  cra_pkg::coord_type             rect_x,
   input  cra_pkg::coord_type             rect_y,
   input  cra_pkg::coord_type             rect_width,
   input  cra_pkg::coord_type             rect_height,
   input  logic [cra_pkg::SCORE_BITS-1:0] score,
   input  logic                           must_keep,
   input  logic                           last,
   input  logic [cra_pkg::FRAC_BITS-1:0]  min_coverage_fraction,
   output cra_pkg::item_type              item
);
   import cra_pkg::*;

   localparam int PROD_BITS = COORD_BITS + FRAC_BITS + 1;

   logic [FRAC_BITS-1:0] comp;
   logic [PROD_BITS-1:0] prod_h;
   logic [PROD_BITS-1:0] prod_v;

   // trim per end = ceil((256 - f) * len / 512), f clamped to one
   assign comp = (min_coverage_fraction > FRAC_ONE) ? '0 : FRAC_ONE - min_coverage_fraction;
   assign prod_h = PROD_BITS'(comp) * PROD_BITS'(rect_width) + PROD_BITS'(511);
   assign prod_v = PROD_BITS'(comp) * PROD_BITS'(rect_height) + PROD_BITS'(511);

   always_comb begin
      item.x = rect_x;
      item.y = rect_y;
      item.w = rect_width;
      item.h = rect_height;
      item.xr = WIDE_BITS'(rect_x) + WIDE_BITS'(rect_width);
      item.yb = WIDE_BITS'(rect_y) + WIDE_BITS'(rect_height);
      item.cx = WIDE_BITS'(rect_x) + WIDE_BITS'(rect_width >> 1);
      item.cy = WIDE_BITS'(rect_y) + WIDE_BITS'(rect_height >> 1);
      item.trim_h = prod_h[COORD_BITS+8:9];
      item.trim_v = prod_v[COORD_BITS+8:9];
      item.score_ok = ~score[SCORE_BITS-1];
      item.score_mag = score[MAG_BITS-1:0];
      item.required = must_keep;
      item.last = last;
   end

endmodule

// ===== hw/rtl/cra_queue.sv =====
// Short queue between front and back end.
module cra_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cra_pkg::item_type push_item,
   input  logic              pop,
   output cra_pkg::item_type pop_item,
   output logic              not_empty,
   output logic              full
);
   import cra_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

   item_type slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full = (count_ff == CNT_FULL);
   assign pop_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

endmodule

// ===== hw/rtl/cra_back.sv =====
// Back end: merges requests into the crop, keeps frame state, holds the result.
module cra_back (
   input  logic                          clock,
   input  logic                          reset,
   input  cra_pkg::item_type             item,
   input  logic                          item_valid,
   output logic                          pop,
   input  cra_pkg::cfg_type              cfg,
   input  cra_pkg::coord_type            width_cap,
   input  cra_pkg::coord_type            height_cap,
   input  logic [cra_pkg::MODE_BITS-1:0] score_mode,
   output cra_pkg::result_type           result,
   output logic                          result_valid,
   input  logic                          result_ready
);
   import cra_pkg::*;

   typedef struct packed {
      logic [1:0] grade;
      wide_type l;
      wide_type r;
   } merge_type;

   function automatic wide_type wmax(input wide_type a, input wide_type b);
      return (a > b) ? a : b;
   endfunction

   function automatic wide_type wmin(input wide_type a, input wide_type b);
      return (a < b) ? a : b;
   endfunction

   function automatic merge_type merge_axis(input wide_type al, input wide_type ar,
                                            input wide_type bl, input wide_type br,
                                            input coord_type trim, input wide_type lim);
      wide_type fl, fr, cl, cr;
      merge_type m;
      fl = wmin(al, bl);
      fr = wmax(ar, br);
      cl = wmin(al + WIDE_BITS'(trim), bl);
      cr = wmax(ar - WIDE_BITS'(trim), br);
      if (fr - fl <= lim) begin
         m.grade = COVER_FULL;
         m.l = fl;
         m.r = fr;
      end else if (cr - cl <= lim) begin
         m.grade = COVER_PART;
         m.l = cl;
         m.r = cr;
      end else begin
         m.grade = COVER_NOT;
         m.l = bl;
         m.r = br;
      end
      return m;
   endfunction

   function automatic acc_type add_score(input acc_type acc, input logic ok,
                                         input logic [MAG_BITS-1:0] mag, input logic req,
                                         input logic [MODE_BITS-1:0] mode);
      logic [ACC_BITS:0] sum;
      acc_type res;
      sum = {1'b0, acc} + (ACC_BITS + 1)'(mag);
      res = acc;
      if (ok) begin
         case (mode)
            MODE_MAX: res = (ACC_BITS'(mag) > acc) ? ACC_BITS'(mag) : acc;
            MODE_SUM_REQ: begin
               if (req) begin
                  res = sum[ACC_BITS] ? SCORE_SAT : sum[ACC_BITS-1:0];
               end
            end
            MODE_SUM_ALL: res = sum[ACC_BITS] ? SCORE_SAT : sum[ACC_BITS-1:0];
            default: res = SCORE_ONE;
         endcase
      end
      return res;
   endfunction

   wide_type crop_left_ff, crop_left_in;
   wide_type crop_top_ff, crop_top_in;
   wide_type crop_w_ff, crop_w_in;
   wide_type crop_h_ff, crop_h_in;
   logic crop_is_empty_ff, crop_is_empty_in;
   logic seen_required_ff, seen_required_in;
   wide_type limit_w_ff, limit_w_in;
   wide_type limit_h_ff, limit_h_in;
   acc_type score_acc_ff, score_acc_in;
   tally_type covered_tally_ff, covered_tally_in;
   tally_type optional_tally_ff, optional_tally_in;
   logic result_valid_ff, result_valid_in;
   result_type result_ff, result_in;

   wide_type base_l, base_r, base_t, base_b;
   merge_type mh, mv;

   // a last request may only leave the queue once the result slot is free
   assign pop = item_valid && (!item.last || !result_valid_ff || result_ready);
   assign result_valid = result_valid_ff;
   assign result = result_ff;

   always_comb begin
      // an empty crop stands in as a point at the request's centre
      base_l = crop_is_empty_ff ? item.cx : crop_left_ff;
      base_r = crop_is_empty_ff ? item.cx : crop_left_ff + crop_w_ff;
      base_t = crop_is_empty_ff ? item.cy : crop_top_ff;
      base_b = crop_is_empty_ff ? item.cy : crop_top_ff + crop_h_ff;
      mh = merge_axis(WIDE_BITS'(item.x), item.xr, base_l, base_r, item.trim_h, limit_w_ff);
      mv = merge_axis(WIDE_BITS'(item.y), item.yb, base_t, base_b, item.trim_v, limit_h_ff);
   end

   always_comb begin
      crop_left_in = crop_left_ff;
      crop_top_in = crop_top_ff;
      crop_w_in = crop_w_ff;
      crop_h_in = crop_h_ff;
      crop_is_empty_in = crop_is_empty_ff;
      seen_required_in = seen_required_ff;
      limit_w_in = limit_w_ff;
      limit_h_in = limit_h_ff;
      score_acc_in = score_acc_ff;
      covered_tally_in = covered_tally_ff;
      optional_tally_in = optional_tally_ff;
      result_in = '0;
      if (pop) begin
         if (item.required) begin
            if (crop_is_empty_ff) begin
               crop_left_in = WIDE_BITS'(item.x);
               crop_top_in = WIDE_BITS'(item.y);
               crop_w_in = WIDE_BITS'(item.w);
               crop_h_in = WIDE_BITS'(item.h);
            end else begin
               crop_left_in = wmin(WIDE_BITS'(item.x), crop_left_ff);
               crop_top_in = wmin(WIDE_BITS'(item.y), crop_top_ff);
               crop_w_in = wmax(item.xr, crop_left_ff + crop_w_ff) - crop_left_in;
               crop_h_in = wmax(item.yb, crop_top_ff + crop_h_ff) - crop_top_in;
            end
            crop_is_empty_in = 1'b0;
            seen_required_in = 1'b1;
            limit_w_in = wmax(limit_w_ff, crop_w_in);
            limit_h_in = wmax(limit_h_ff, crop_h_in);
            score_acc_in = add_score(score_acc_ff, item.score_ok, item.score_mag, 1'b1,
                                     score_mode);
         end else begin
            if (optional_tally_ff != TALLY_SAT) begin
               optional_tally_in = optional_tally_ff + 1'b1;
            end
            if (mh.grade != COVER_NOT && mv.grade != COVER_NOT) begin
               crop_left_in = mh.l;
               crop_top_in = mv.l;
               crop_w_in = mh.r - mh.l;
               crop_h_in = mv.r - mv.l;
               crop_is_empty_in = 1'b0;
               if (mh.grade == COVER_FULL && mv.grade == COVER_FULL) begin
                  if (covered_tally_ff != TALLY_SAT) begin
                     covered_tally_in = covered_tally_ff + 1'b1;
                  end
                  score_acc_in = add_score(score_acc_ff, item.score_ok, item.score_mag,
                                           1'b0, score_mode);
               end
            end
         end
         result_in.x = crop_is_empty_in ? '0 : crop_left_in;
         result_in.y = crop_is_empty_in ? '0 : crop_top_in;
         result_in.w = crop_is_empty_in ? '0 : crop_w_in;
         result_in.h = crop_is_empty_in ? '0 : crop_h_in;
         result_in.region_empty = crop_is_empty_in;
         result_in.required_empty = !seen_required_in;
         result_in.required_fits = !seen_required_in ||
            (limit_w_in <= WIDE_BITS'(width_cap) && limit_h_in <= WIDE_BITS'(height_cap));
         result_in.score = score_acc_in;
         result_in.covered = covered_tally_in;
         result_in.optional = optional_tally_in;
         if (item.last) begin
            crop_left_in = '0;
            crop_top_in = '0;
            crop_w_in = '0;
            crop_h_in = '0;
            crop_is_empty_in = 1'b1;
            seen_required_in = 1'b0;
            limit_w_in = WIDE_BITS'(width_cap);
            limit_h_in = WIDE_BITS'(height_cap);
            score_acc_in = '0;
            covered_tally_in = '0;
            optional_tally_in = '0;
         end
      end else begin
         // the user must make target writes only while idle (unenforced); the new value comes with the strobe
         if (cfg.width_we) begin
            limit_w_in = seen_required_ff ? wmax(WIDE_BITS'(cfg.wdata), crop_w_ff)
                                          : WIDE_BITS'(cfg.wdata);
         end
         if (cfg.height_we) begin
            limit_h_in = seen_required_ff ? wmax(WIDE_BITS'(cfg.wdata), crop_h_ff)
                                          : WIDE_BITS'(cfg.wdata);
         end
      end
   end

   always_comb begin
      result_valid_in = result_valid_ff;
      if (pop && item.last) begin
         result_valid_in = 1'b1;
      end else if (result_ready) begin
         result_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crop_left_ff <= '0;
         crop_top_ff <= '0;
         crop_w_ff <= '0;
         crop_h_ff <= '0;
         crop_is_empty_ff <= 1'b1;
         seen_required_ff <= 1'b0;
         limit_w_ff <= WIDE_BITS'(TARGET_W_RESET);
         limit_h_ff <= WIDE_BITS'(TARGET_H_RESET);
         score_acc_ff <= '0;
         covered_tally_ff <= '0;
         optional_tally_ff <= '0;
         result_valid_ff <= 1'b0;
      end else begin
         crop_left_ff <= crop_left_in;
         crop_top_ff <= crop_top_in;
         crop_w_ff <= crop_w_in;
         crop_h_ff <= crop_h_in;
         crop_is_empty_ff <= crop_is_empty_in;
         seen_required_ff <= seen_required_in;
         limit_w_ff <= limit_w_in;
         limit_h_ff <= limit_h_in;
         score_acc_ff <= score_acc_in;
         covered_tally_ff <= covered_tally_in;
         optional_tally_ff <= optional_tally_in;
         result_valid_ff <= result_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && item.last) begin
         result_ff <= result_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (pop && item.last) |=> crop_is_empty_ff && !seen_required_ff && result_valid_ff)
      else $error("frame state not cleared after result");

   a_tally_order: assert property (@(posedge clock) disable iff (reset)
      covered_tally_ff <= optional_tally_ff)
      else $error("covered tally above optional tally");

   a_limit_covers_crop: assert property (@(posedge clock) disable iff (reset)
      seen_required_ff |-> (limit_w_ff >= crop_w_ff && limit_h_ff >= crop_h_ff))
      else $error("limit below required crop size");

endmodule

// ===== hw/rtl/crop_region_accumulator_core.sv =====
// Top level of the crop region accumulator: stream ports, register file, front, queue, back.
//
// Builds one crop region per frame from a stream of detection rectangles, one per request,
// required rectangles first. Required rectangles are unioned into the crop and the size
// limit grows to cover them; each non-required rectangle is merged per axis, fully, by its
// trimmed core, or not at all. Scores gather in unsigned Q16.8 by score_mode and saturate.
// The request marked by tlast makes one result and clears the frame state. Throughput is
// one request per clock: the front end (edges, centre, trim multiplies) writes a two-entry
// queue, and the back end merges one queued request per cycle against the crop registers.
// A last request's result is presented in the cycle after it is taken and then sits in an
// output register; only a last request waiting on a full output register stalls the back
// end. Registers lie at byte addresses 0 (target width), 4 (target height),
// 8 (min_coverage_fraction) and 12 (score_mode); write them only while the block is idle.
module crop_region_accumulator_core (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: rect_x, rect_y, rect_width, rect_height, score (lowest bit up)
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cra_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // req_tuser: required flag
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   // rsp_tdata: region_x, region_y, region_width, region_height, region_score,
   //            covered_count, optional_count (lowest bit up)
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cra_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // rsp_tuser: region_empty, required_empty, required_fits (lowest bit up)
   output logic [cra_pkg::RSP_USER_BITS-1:0]   rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cra_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [cra_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [cra_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import cra_pkg::*;

   coord_type tgt_w_ff;
   coord_type tgt_h_ff;
   logic [FRAC_BITS-1:0] coverage_ff;
   logic [MODE_BITS-1:0] score_mode_ff;

   logic csr_we;
   logic [1:0] csr_index;
   cfg_type cfg;

   item_type front_item;
   item_type queue_item;
   logic queue_valid;
   logic queue_full;
   logic back_pop;
   logic push;
   result_type result;

   // register file
   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[3:2];
   assign csr_we = csr_psel && csr_penable && csr_pwrite;
   assign cfg.width_we = csr_we && (csr_index == REG_TARGET_W);
   assign cfg.height_we = csr_we && (csr_index == REG_TARGET_H);
   assign cfg.wdata = csr_pwdata[COORD_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_w_ff <= TARGET_W_RESET;
         tgt_h_ff <= TARGET_H_RESET;
         coverage_ff <= COVERAGE_RESET;
         score_mode_ff <= MODE_SUM_ALL;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_TARGET_W: tgt_w_ff <= csr_pwdata[COORD_BITS-1:0];
            REG_TARGET_H: tgt_h_ff <= csr_pwdata[COORD_BITS-1:0];
            REG_COVERAGE: coverage_ff <= csr_pwdata[FRAC_BITS-1:0];
            REG_MODE: score_mode_ff <= csr_pwdata[MODE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_TARGET_W: csr_prdata = CSR_DATA_BITS'(tgt_w_ff);
         REG_TARGET_H: csr_prdata = CSR_DATA_BITS'(tgt_h_ff);
         REG_COVERAGE: csr_prdata = CSR_DATA_BITS'(coverage_ff);
         REG_MODE: csr_prdata = CSR_DATA_BITS'(score_mode_ff);
         default: csr_prdata = '0;
      endcase
   end

   // a request is taken whenever the queue has room
   assign req_tready = !queue_full;
   assign push = req_tvalid && req_tready;

   cra_front u_front (
      .rect_x                (req_tdata[COORD_BITS-1:0]),
      .rect_y                (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .rect_width            (req_tdata[3*COORD_BITS-1:2*COORD_BITS]),
      .rect_height           (req_tdata[4*COORD_BITS-1:3*COORD_BITS]),
      .score                 (req_tdata[4*COORD_BITS+SCORE_BITS-1:4*COORD_BITS]),
      .must_keep             (req_tuser),
      .last                  (req_tlast),
      .min_coverage_fraction (coverage_ff),
      .item                  (front_item)
   );

   cra_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .pop       (back_pop),
      .pop_item  (queue_item),
      .not_empty (queue_valid),
      .full      (queue_full)
   );

   cra_back u_back (
      .clock         (clock),
      .reset         (reset),
      .item          (queue_item),
      .item_valid    (queue_valid),
      .pop           (back_pop),
      .cfg           (cfg),
      .width_cap     (tgt_w_ff),
      .height_cap    (tgt_h_ff),
      .score_mode    (score_mode_ff),
      .result        (result),
      .result_valid  (rsp_tvalid),
      .result_ready  (rsp_tready)
   );

   // pack the result, first field lowest
   assign rsp_tdata = RSP_DATA_BITS'({result.optional, result.covered, result.score,
                                      result.h, result.w, result.y, result.x});
   assign rsp_tuser = {result.required_fits, result.required_empty, result.region_empty};

endmodule
